/* hw/rtl/mfes_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfes_pkg
// Shared types and encodings for the function end scanner.
// ----------------------------------------------------------------------------
package mfes_pkg;

    typedef enum logic [1:0] {
        VERDICT_FOUND   = 2'd0,
        VERDICT_UNKNOWN = 2'd1,
        VERDICT_NORET   = 2'd2,
        VERDICT_EMPTY   = 2'd3
    } verdict_t;

    typedef struct packed {
        logic        first;
        logic [31:0] word;
        logic [31:0] start_addr;
        logic [31:0] limit_addr;
    } in_item_t;

    typedef struct packed {
        verdict_t    verdict;
        logic [31:0] end_addr;
    } out_item_t;

    // Decoded view of one instruction word
    typedef struct packed {
        logic        known;
        logic        is_load;
        logic        is_branch;
        logic        is_jr;
        logic [4:0]  rs;
        logic [4:0]  dst;
        logic [31:0] target;
    } dec_t;

    localparam logic [5:0] OP_FUNCT   = 6'h00;
    localparam logic [5:0] OP_BCOND   = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_COP0    = 6'h10;
    localparam logic [5:0] OP_COP2    = 6'h12;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LWR     = 6'h26;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SW      = 6'h2B;
    localparam logic [5:0] OP_SWR     = 6'h2E;
    localparam logic [5:0] OP_LWC2    = 6'h32;
    localparam logic [5:0] OP_SWC2    = 6'h3A;

    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_DIVU    = 6'h1B;

    localparam logic [4:0] REG_ZERO   = 5'd0;
    localparam logic [4:0] REG_LINK   = 5'd31;

endpackage

/* hw/rtl/mfes_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfes_decode
// Instruction classifier: known encoding, load, branch target, jr and the
// tracked destination register of one word.
// ----------------------------------------------------------------------------
module mfes_decode (
    input  logic [31:0]        word,
    input  logic [31:0]        addr,
    output mfes_pkg::dec_t     dec
);

    logic [5:0]  op;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [5:0]  fn;
    logic [31:0] pc4;

    assign op  = word[31:26];
    assign rs  = word[25:21];
    assign rt  = word[20:16];
    assign rd  = word[15:11];
    assign fn  = word[5:0];
    assign pc4 = addr + 32'd4;

    always_comb
    begin
        case (op)
            mfes_pkg::OP_FUNCT:
                dec.known = fn inside {6'h00, 6'h02, 6'h03, 6'h04, 6'h06, 6'h07,
                                       6'h08, 6'h09, 6'h0C, 6'h0D, 6'h10, 6'h11,
                                       6'h12, 6'h13, 6'h18, 6'h19, 6'h1A, 6'h1B,
                                       6'h20, 6'h21, 6'h22, 6'h23, 6'h24, 6'h25,
                                       6'h26, 6'h27, 6'h2A, 6'h2B};
            mfes_pkg::OP_BCOND:
                dec.known = rt inside {5'h00, 5'h01, 5'h10, 5'h11};
            mfes_pkg::OP_COP0:
                dec.known = rs inside {5'd0, 5'd4, 5'd16};
            mfes_pkg::OP_COP2:
                dec.known = word[25] || (rs inside {5'd0, 5'd2, 5'd4, 5'd6, 5'd8});
            default:
                dec.known = (op inside {[mfes_pkg::OP_J:mfes_pkg::OP_LUI],
                                        [mfes_pkg::OP_LB:mfes_pkg::OP_LWR],
                                        [mfes_pkg::OP_SB:mfes_pkg::OP_SW],
                                        mfes_pkg::OP_SWR, mfes_pkg::OP_LWC2,
                                        mfes_pkg::OP_SWC2});
        endcase

        dec.is_load   = op inside {[mfes_pkg::OP_LB:mfes_pkg::OP_LWR]};
        dec.is_branch = (op == mfes_pkg::OP_BCOND)
                     || (op inside {[mfes_pkg::OP_J:mfes_pkg::OP_BGTZ]});
        dec.is_jr     = (op == mfes_pkg::OP_FUNCT) && (fn == mfes_pkg::FN_JR);
        dec.rs        = rs;

        // jumps keep the top nibble of pc+4, branches are pc-relative
        if (op == mfes_pkg::OP_J || op == mfes_pkg::OP_JAL)
        begin
            dec.target = {pc4[31:28], word[25:0], 2'b00};
        end
        else
        begin
            dec.target = pc4 + {{14{word[15]}}, word[15:0], 2'b00};
        end

        if (op == mfes_pkg::OP_FUNCT)
        begin
            if (fn inside {mfes_pkg::FN_JR, mfes_pkg::FN_JALR, mfes_pkg::FN_MTHI,
                           mfes_pkg::FN_MTLO, mfes_pkg::FN_MULT, mfes_pkg::FN_MULTU,
                           mfes_pkg::FN_DIV, mfes_pkg::FN_DIVU})
            begin
                dec.dst = mfes_pkg::REG_ZERO;
            end
            else
            begin
                dec.dst = rd;
            end
        end
        else if (dec.is_load || (op inside {[mfes_pkg::OP_ADDI:mfes_pkg::OP_LUI]}))
        begin
            dec.dst = rt;
        end
        else
        begin
            dec.dst = mfes_pkg::REG_ZERO;
        end
    end

endmodule

/* hw/rtl/mfes_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfes_core
// Scan state and per-word step: target tracking, register flags, end test.
// ----------------------------------------------------------------------------
module mfes_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  mfes_pkg::in_item_t   item,
    output logic                 res_valid,
    output mfes_pkg::out_item_t  res
);

    logic        busy_reg,  busy_next;
    logic        await_reg, await_next;
    logic [31:0] cs_reg,    cs_next;
    logic [31:0] lim_reg,   lim_next;
    logic [31:0] cur_reg,   cur_next;
    logic [31:0] ft_reg,    ft_next;
    logic [31:0] pend_reg,  pend_next;
    logic [31:0] wr_reg,    wr_next;
    logic [31:0] ld_reg,    ld_next;

    logic [31:0] eff_cs, eff_lim, eff_cur, eff_ft, eff_pend, eff_wr, eff_ld;
    logic        eff_await;
    logic        empty;
    logic        jr_ends;
    logic [32:0] lim33, cur4, cur8, end33;
    logic [31:0] dst_bit;
    mfes_pkg::dec_t dec;

    // a new candidate overrides everything left from the previous one
    assign eff_cs    = item.first ? item.start_addr : cs_reg;
    assign eff_lim   = item.first ? item.limit_addr : lim_reg;
    assign eff_cur   = item.first ? item.start_addr : cur_reg;
    assign eff_ft    = item.first ? item.start_addr : ft_reg;
    assign eff_pend  = item.first ? 32'd0 : pend_reg;
    assign eff_wr    = item.first ? 32'd0 : wr_reg;
    assign eff_ld    = item.first ? 32'd0 : ld_reg;
    assign eff_await = item.first ? 1'b0 : await_reg;

    assign lim33 = {1'b0, eff_lim};
    assign cur4  = {1'b0, eff_cur} + 33'd4;
    assign cur8  = {1'b0, eff_cur} + 33'd8;
    assign end33 = (cur8 > lim33) ? lim33 : cur8;
    assign empty = ({1'b0, item.start_addr} + 33'd4) > {1'b0, item.limit_addr};

    mfes_decode u_decode (
        .word (item.word),
        .addr (eff_cur),
        .dec  (dec)
    );

    assign jr_ends = dec.is_jr
                  && ((dec.rs == mfes_pkg::REG_LINK) || !eff_wr[dec.rs] || !eff_ld[dec.rs]);
    assign dst_bit = 32'd1 << dec.dst;

    always_comb
    begin
        busy_next  = busy_reg;
        await_next = await_reg;
        cs_next    = cs_reg;
        lim_next   = lim_reg;
        cur_next   = cur_reg;
        ft_next    = ft_reg;
        pend_next  = pend_reg;
        wr_next    = wr_reg;
        ld_next    = ld_reg;
        res_valid  = 1'b0;
        res        = '{verdict: mfes_pkg::VERDICT_FOUND, end_addr: 32'd0};

        if (step && (item.first || busy_reg))
        begin
            busy_next  = 1'b1;
            await_next = eff_await;
            cs_next    = eff_cs;
            lim_next   = eff_lim;
            cur_next   = eff_cur;
            ft_next    = eff_ft;
            pend_next  = eff_pend;
            wr_next    = eff_wr;
            ld_next    = eff_ld;

            if (item.first && empty)
            begin
                res_valid   = 1'b1;
                res.verdict = mfes_pkg::VERDICT_EMPTY;
            end
            else if (eff_await)
            begin
                // delay slot: only the encoding is checked
                res_valid = 1'b1;
                if (dec.known)
                begin
                    res.end_addr = eff_pend;
                end
                else
                begin
                    res.verdict = mfes_pkg::VERDICT_UNKNOWN;
                end
            end
            else if (!dec.known)
            begin
                res_valid   = 1'b1;
                res.verdict = mfes_pkg::VERDICT_UNKNOWN;
            end
            else
            begin
                if (dec.is_branch && (dec.target > eff_ft) && (dec.target > eff_cs)
                    && (dec.target < eff_lim))
                begin
                    ft_next = dec.target;
                end

                if (jr_ends && (eff_cur >= eff_ft))
                begin
                    if (cur4 < end33)
                    begin
                        pend_next  = end33[31:0];
                        cur_next   = cur4[31:0];
                        await_next = 1'b1;
                    end
                    else
                    begin
                        res_valid    = 1'b1;
                        res.end_addr = end33[31:0];
                    end
                end
                else
                begin
                    if (dec.dst != mfes_pkg::REG_ZERO)
                    begin
                        wr_next = eff_wr | dst_bit;
                        ld_next = dec.is_load ? (eff_ld | dst_bit) : (eff_ld & ~dst_bit);
                    end
                    if (cur8 > lim33)
                    begin
                        res_valid   = 1'b1;
                        res.verdict = mfes_pkg::VERDICT_NORET;
                    end
                    else
                    begin
                        cur_next = cur4[31:0];
                    end
                end
            end

            // any result closes the candidate
            if (res_valid)
            begin
                busy_next  = 1'b0;
                await_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            await_reg <= 1'b0;
            cs_reg    <= 32'd0;
            lim_reg   <= 32'd0;
            cur_reg   <= 32'd0;
            ft_reg    <= 32'd0;
            pend_reg  <= 32'd0;
            wr_reg    <= 32'd0;
            ld_reg    <= 32'd0;
        end
        else
        begin
            busy_reg  <= busy_next;
            await_reg <= await_next;
            cs_reg    <= cs_next;
            lim_reg   <= lim_next;
            cur_reg   <= cur_next;
            ft_reg    <= ft_next;
            pend_reg  <= pend_next;
            wr_reg    <= wr_next;
            ld_reg    <= ld_next;
        end
    end

    a_await_busy: assert property (@(posedge clk) disable iff (!rst_n)
        await_reg |-> busy_reg)
        else $error("delay word awaited while idle");

    a_idle_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !item.first && !busy_reg) |-> !res_valid)
        else $error("result from an item taken while idle");

    a_cur_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cur_reg >= cs_reg))
        else $error("scan address below candidate start");

    a_found_end_only: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && (res.verdict != mfes_pkg::VERDICT_FOUND)) |-> (res.end_addr == 32'd0))
        else $error("end address on a failed candidate");

endmodule

/* hw/rtl/mips_function_end_scanner.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_function_end_scanner
// Walks instruction words of a candidate function and reports where its
// body ends, or why it was rejected.
// ----------------------------------------------------------------------------
//   channel | direction | payload                          | handshake
//   in      | into      | first, word, start_addr, limit   | in_valid / in_stall
//   out     | out of    | verdict, end_addr                | out_valid / out_stall
//
// One word per cycle unless out_stall holds the output: an item is held in the
// input register, is stepped through the decode and scan logic, and its
// result (if any) lands in the output register, whose valid is out_valid.
// Reset clears the scan state and both pipeline valids; no clearing pass.
// in_stall rises only while the input register holds an item and the output
// register is full and stalled.
// ----------------------------------------------------------------------------
module mips_function_end_scanner (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  mfes_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_stall,
    output mfes_pkg::out_item_t  out_item
);

    logic                 in_vld_reg, in_vld_next;
    mfes_pkg::in_item_t   in_data_reg;
    logic                 out_vld_reg, out_vld_next;
    mfes_pkg::out_item_t  out_data_reg;
    logic                 adv;
    logic                 take;
    logic                 res_valid;
    mfes_pkg::out_item_t  res;

    // step the held item whenever the result slot can take its outcome
    assign adv      = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !adv;
    assign take     = in_valid && !in_stall;

    assign out_valid = out_vld_reg;
    assign out_item  = out_data_reg;

    mfes_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (adv),
        .item      (in_data_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (take)
        begin
            in_vld_next = 1'b1;
        end
        else if (adv)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (adv && res_valid)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_vld_reg && !out_stall)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= in_item;
        end
        if (adv && res_valid)
        begin
            out_data_reg <= res;
        end
    end

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_vld_reg && out_vld_reg && out_stall))
        else $error("input stalled without output backpressure");

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && res_valid) |=> out_vld_reg)
        else $error("scan result lost");

endmodule

/* dv/mips_function_end_scanner_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_function_end_scanner_tb
// Drives candidate function bodies into the scanner and compares every
// verdict and end address with a cycle-free model of the scan kept in the
// bench. Directed cases cover the boundary conditions; random candidates
// of well-formed code mixed with noise exercise the rest under three
// handshake idle profiles.
// ----------------------------------------------------------------------------
module mips_function_end_scanner_tb;

    localparam int unsigned CYCLE_LIMIT = 400000;

    // Lookup masks of the encodings the scanner accepts
    localparam logic [63:0] SPECIAL_FN_KNOWN = 64'h0000_0CFF_0F0F_33DD;
    localparam logic [63:0] PRIMARY_OP_KNOWN = 64'h0404_4F7F_0000_FFFC;
    localparam logic [31:0] REGIMM_RT_KNOWN  = 32'h0003_0003;
    localparam logic [31:0] COP0_RS_KNOWN    = 32'h0001_0011;
    localparam logic [31:0] COP2_RS_KNOWN    = 32'h0000_0155;

    localparam logic [31:0] NOP_WORD = 32'h0000_0000;
    localparam logic [31:0] BAD_WORD = 32'hFFFF_FFFF;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    mfes_pkg::in_item_t  in_item;
    logic                out_valid;
    logic                out_stall = 1'b0;
    mfes_pkg::out_item_t out_item;

    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;
    int unsigned err_count = 0;
    int unsigned cycle_count = 0;

    // Scan state of the bench-side model
    bit          scan_busy;
    bit          delay_pending;
    logic [31:0] cand_start;
    logic [31:0] cand_limit;
    logic [31:0] cur_pc;
    logic [31:0] far_target;
    logic [31:0] end_pending;
    logic [31:0] gpr_written;
    logic [31:0] gpr_from_load;

    mfes_pkg::out_item_t expected_verdicts[$];
    mfes_pkg::out_item_t predicted;
    mfes_pkg::out_item_t want;

    mips_function_end_scanner u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Decode helpers
    // ------------------------------------------------------------------------
    function automatic bit is_load_op(input logic [5:0] op);
        return op >= mfes_pkg::OP_LB && op <= mfes_pkg::OP_LWR;
    endfunction

    function automatic bit is_known(input logic [31:0] w);
        logic [5:0] op;
        logic [4:0] rs;
        op = w[31:26];
        rs = w[25:21];
        case (op)
            mfes_pkg::OP_FUNCT: return SPECIAL_FN_KNOWN[w[5:0]];
            mfes_pkg::OP_BCOND: return REGIMM_RT_KNOWN[w[20:16]];
            mfes_pkg::OP_COP0:  return COP0_RS_KNOWN[rs];
            mfes_pkg::OP_COP2:  return w[25] || COP2_RS_KNOWN[rs];
            default:            return PRIMARY_OP_KNOWN[op];
        endcase
    endfunction

    function automatic logic [4:0] dest_of(input logic [31:0] w);
        logic [5:0] op;
        op = w[31:26];
        if (op == mfes_pkg::OP_FUNCT)
        begin
            case (w[5:0])
                mfes_pkg::FN_JR, mfes_pkg::FN_JALR, mfes_pkg::FN_MTHI, mfes_pkg::FN_MTLO,
                mfes_pkg::FN_MULT, mfes_pkg::FN_MULTU, mfes_pkg::FN_DIV,
                mfes_pkg::FN_DIVU: return mfes_pkg::REG_ZERO;
                default: return w[15:11];
            endcase
        end
        if (is_load_op(op) || (op >= mfes_pkg::OP_ADDI && op <= mfes_pkg::OP_LUI))
            return w[20:16];
        return mfes_pkg::REG_ZERO;
    endfunction

    // ------------------------------------------------------------------------
    // Advance the model by one accepted item; returns 1 when a verdict falls
    // ------------------------------------------------------------------------
    function automatic bit scan_step(input mfes_pkg::in_item_t it,
                                     output mfes_pkg::out_item_t res);
        logic [31:0] w;
        logic [31:0] pc;
        logic [31:0] tgt;
        logic [32:0] end_wide;
        logic [5:0]  op;
        logic [4:0]  r;
        logic [4:0]  dst;
        bit          ends;
        w = it.word;
        op = w[31:26];
        res.verdict = mfes_pkg::VERDICT_FOUND;
        res.end_addr = '0;

        if (it.first)
        begin
            cand_start = it.start_addr;
            cand_limit = it.limit_addr;
            cur_pc = it.start_addr;
            far_target = it.start_addr;
            end_pending = '0;
            gpr_written = '0;
            gpr_from_load = '0;
            delay_pending = 1'b0;
            scan_busy = 1'b1;
            // no whole word fits; compare without wrap
            if ({1'b0, cand_start} + 33'd4 > {1'b0, cand_limit})
            begin
                scan_busy = 1'b0;
                res.verdict = mfes_pkg::VERDICT_EMPTY;
                return 1'b1;
            end
        end
        else if (!scan_busy)
        begin
            return 1'b0;
        end

        if (delay_pending)
        begin
            scan_busy = 1'b0;
            delay_pending = 1'b0;
            if (is_known(w))
                res.end_addr = end_pending;
            else
                res.verdict = mfes_pkg::VERDICT_UNKNOWN;
            return 1'b1;
        end

        if (!is_known(w))
        begin
            scan_busy = 1'b0;
            res.verdict = mfes_pkg::VERDICT_UNKNOWN;
            return 1'b1;
        end

        pc = cur_pc;
        if (op == mfes_pkg::OP_BCOND || (op >= mfes_pkg::OP_J && op <= mfes_pkg::OP_BGTZ))
        begin
            if (op == mfes_pkg::OP_J || op == mfes_pkg::OP_JAL)
            begin
                tgt = pc + 32'd4;
                tgt = {tgt[31:28], w[25:0], 2'b00};
            end
            else
            begin
                tgt = pc + 32'd4 + {{14{w[15]}}, w[15:0], 2'b00};
            end
            if (tgt > far_target && tgt > cand_start && tgt < cand_limit)
                far_target = tgt;
        end

        ends = 1'b0;
        if (op == mfes_pkg::OP_FUNCT && w[5:0] == mfes_pkg::FN_JR)
        begin
            r = w[25:21];
            ends = (r == mfes_pkg::REG_LINK) || !gpr_written[r] || !gpr_from_load[r];
        end

        if (ends && pc >= far_target)
        begin
            end_wide = {1'b0, pc} + 33'd8;
            if (end_wide > {1'b0, cand_limit})
                end_wide = {1'b0, cand_limit};
            if ({1'b0, pc} + 33'd4 < end_wide)
            begin
                end_pending = end_wide[31:0];
                cur_pc = pc + 32'd4;
                delay_pending = 1'b1;
                return 1'b0;
            end
            scan_busy = 1'b0;
            res.end_addr = end_wide[31:0];
            return 1'b1;
        end

        dst = dest_of(w);
        if (dst != mfes_pkg::REG_ZERO)
        begin
            gpr_written[dst] = 1'b1;
            gpr_from_load[dst] = is_load_op(op);
        end

        if ({1'b0, pc} + 33'd8 > {1'b0, cand_limit})
        begin
            scan_busy = 1'b0;
            res.verdict = mfes_pkg::VERDICT_NORET;
            return 1'b1;
        end
        cur_pc = pc + 32'd4;
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Scoreboard: predict on input accept, compare on output accept
    // ------------------------------------------------------------------------
    task automatic flag_error(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (scan_step(in_item, predicted))
                    expected_verdicts.insert(expected_verdicts.size(), predicted);
            end
            if (out_valid && !out_stall)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    flag_error($sformatf("unexpected result verdict=%s end_addr=%h",
                                         out_item.verdict.name(), out_item.end_addr));
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (out_item.verdict !== want.verdict)
                        flag_error($sformatf("verdict expected %s got %s",
                                             want.verdict.name(), out_item.verdict.name()));
                    if (out_item.end_addr !== want.end_addr)
                        flag_error($sformatf("end_addr expected %h got %h",
                                             want.end_addr, out_item.end_addr));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < snk_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("mips_function_end_scanner_tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_item(input mfes_pkg::in_item_t it);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic push_word(input logic first, input logic [31:0] word,
                             input logic [31:0] start_addr, input logic [31:0] limit_addr);
        mfes_pkg::in_item_t it;
        it.first = first;
        it.word = word;
        it.start_addr = start_addr;
        it.limit_addr = limit_addr;
        send_item(it);
    endtask

    // Hold the input idle until every predicted verdict has come back
    task automatic wait_results_done();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] jr_word(input logic [4:0] r);
        return {mfes_pkg::OP_FUNCT, r, 15'd0, mfes_pkg::FN_JR};
    endfunction

    function automatic logic [31:0] imm_word(input logic [5:0] op, input logic [4:0] rs,
                                             input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // Bias register picks toward a few registers so writes and jr's collide
    function automatic logic [4:0] pick_reg();
        if ($urandom_range(0, 2) == 0)
            return mfes_pkg::REG_LINK;
        return 5'($urandom_range(0, 3));
    endfunction

    function automatic logic [31:0] body_word(input logic [31:0] pc);
        logic [31:0] w;
        logic [31:0] tgt;
        logic [5:0]  fn;
        logic [5:0]  op;
        logic [4:0]  rt;
        int          off;
        case ($urandom_range(0, 11))
            0, 1:
            begin
                do
                    fn = 6'($urandom_range(0, 63));
                while (!SPECIAL_FN_KNOWN[fn]);
                w = {mfes_pkg::OP_FUNCT, 5'($urandom), 5'($urandom), pick_reg(),
                     5'($urandom), fn};
            end
            2: w = imm_word(6'($urandom_range(mfes_pkg::OP_ADDI, mfes_pkg::OP_LUI)),
                            5'($urandom), pick_reg(), 16'($urandom));
            3, 4: w = imm_word(6'($urandom_range(mfes_pkg::OP_LB, mfes_pkg::OP_LWR)),
                               5'($urandom), pick_reg(), 16'($urandom));
            5:
            begin
                if ($urandom_range(0, 4) == 0)
                    op = mfes_pkg::OP_BCOND;
                else
                    op = 6'($urandom_range(mfes_pkg::OP_JAL + 1, mfes_pkg::OP_BGTZ));
                do
                    rt = 5'($urandom);
                while (op == mfes_pkg::OP_BCOND && !REGIMM_RT_KNOWN[rt]);
                off = $urandom_range(0, 10);
                off = off - 2;
                w = imm_word(op, 5'($urandom), rt, 16'(off));
            end
            6:
            begin
                tgt = pc + 32'd4 * $urandom_range(0, 10);
                w = {($urandom_range(0, 1) != 0) ? mfes_pkg::OP_J : mfes_pkg::OP_JAL,
                     tgt[27:2]};
            end
            7, 8: w = jr_word(pick_reg());
            9:
            begin
                case ($urandom_range(0, 4))
                    0: op = mfes_pkg::OP_COP0;
                    1: op = mfes_pkg::OP_COP2;
                    2: op = mfes_pkg::OP_LWC2;
                    3: op = mfes_pkg::OP_SWC2;
                    default: op = 6'($urandom_range(mfes_pkg::OP_SB, mfes_pkg::OP_SWR));
                endcase
                w = {op, 26'($urandom)};
            end
            default:
            begin
                do
                    w = $urandom;
                while (!is_known(w));
            end
        endcase
        // break the sequence now and then
        if ($urandom_range(0, 39) == 0)
            w = $urandom;
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_idle_and_empty();
        push_word(1'b0, BAD_WORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_word(1'b1, NOP_WORD, 32'h0000_0000, 32'h0000_0000);
        push_word(1'b1, NOP_WORD, 32'hFFFF_FFFC, 32'hFFFF_FFFF);
    endtask

    task automatic test_return_cases();
        push_word(1'b1, jr_word(mfes_pkg::REG_LINK), 32'h0000_1000, 32'h0000_1008);
        push_word(1'b0, NOP_WORD, 32'h0, 32'h0);
        // delay slot beyond the limit
        push_word(1'b1, jr_word(mfes_pkg::REG_LINK), 32'h0000_2000, 32'h0000_2004);
        // delay slot only partly below the limit
        push_word(1'b1, jr_word(mfes_pkg::REG_LINK), 32'h0000_3000, 32'h0000_3006);
        push_word(1'b0, NOP_WORD, 32'h0, 32'h0);
        // unknown delay word
        push_word(1'b1, jr_word(mfes_pkg::REG_LINK), 32'h0000_4000, 32'hFFFF_FFFF);
        push_word(1'b0, BAD_WORD, 32'h0, 32'h0);
        // jr of a never-written register, lowest start
        push_word(1'b1, jr_word(5'd7), 32'h0000_0000, 32'h0000_0100);
        push_word(1'b0, NOP_WORD, 32'h0, 32'h0);
    endtask

    task automatic test_rejects();
        push_word(1'b1, BAD_WORD, 32'h0000_5000, 32'h0000_6000);
        // next word cannot fit below the limit
        push_word(1'b1, NOP_WORD, 32'hFFFF_FFF8, 32'hFFFF_FFFF);
    endtask

    task automatic test_register_tracking();
        push_word(1'b1, imm_word(mfes_pkg::OP_LB, mfes_pkg::REG_ZERO, 5'd2, 16'd0),
                  32'h0000_8000, 32'h0000_9000);
        push_word(1'b0, jr_word(5'd2), 32'h0, 32'h0);
        push_word(1'b0, imm_word(mfes_pkg::OP_ADDI, mfes_pkg::REG_ZERO, 5'd2, 16'd1),
                  32'h0, 32'h0);
        push_word(1'b0, jr_word(5'd2), 32'h0, 32'h0);
        push_word(1'b0, NOP_WORD, 32'h0, 32'h0);
    endtask

    task automatic test_forward_targets();
        push_word(1'b1, imm_word(mfes_pkg::OP_BGTZ, 5'd1, mfes_pkg::REG_ZERO, 16'd2),
                  32'h0000_A000, 32'h0000_B000);
        push_word(1'b0, jr_word(mfes_pkg::REG_LINK), 32'h0, 32'h0);
        push_word(1'b0, NOP_WORD, 32'h0, 32'h0);
        push_word(1'b0, jr_word(mfes_pkg::REG_LINK), 32'h0, 32'h0);
        push_word(1'b0, NOP_WORD, 32'h0, 32'h0);
    endtask

    task automatic test_address_wrap();
        // branch target wraps past zero and is not tracked
        push_word(1'b1, imm_word(mfes_pkg::OP_BGTZ, 5'd1, mfes_pkg::REG_ZERO, 16'h7FFF),
                  32'hFFFF_FFF0, 32'hFFFF_FFFF);
        push_word(1'b0, {mfes_pkg::OP_J, 26'h3FF_FFFF}, 32'h0, 32'h0);
        push_word(1'b0, jr_word(mfes_pkg::REG_LINK), 32'h0, 32'h0);
    endtask

    task automatic scan_candidate();
        mfes_pkg::in_item_t it;
        logic [31:0] base;
        logic [31:0] lim;
        logic [31:0] pc;
        logic [32:0] lim_wide;
        int unsigned len;
        int unsigned n;
        case ($urandom_range(0, 9))
            0: base = $urandom;
            1: base = 32'hFFFF_FFFC - 32'd4 * $urandom_range(0, 8);
            default: base = $urandom & 32'hFFFF_FFFC;
        endcase
        if ($urandom_range(0, 7) == 0)
            len = $urandom_range(0, 2);
        else
            len = $urandom_range(3, 16);
        lim_wide = {1'b0, base} + 33'd4 * len;
        if ($urandom_range(0, 9) == 0)
            lim_wide = lim_wide + $urandom_range(1, 3);
        lim = lim_wide[32] ? 32'hFFFF_FFFF : lim_wide[31:0];
        if ($urandom_range(0, 19) == 0)
            lim = $urandom;
        n = len + $urandom_range(1, 2);
        // drop some scans early so the next start cuts them off
        if ($urandom_range(0, 7) == 0)
            n = $urandom_range(1, len + 1);

        it.first = 1'b1;
        it.start_addr = base;
        it.limit_addr = lim;
        pc = base;
        for (int unsigned i = 0; i < n; i++)
        begin
            it.word = body_word(pc);
            send_item(it);
            it.first = 1'b0;
            it.start_addr = $urandom;
            it.limit_addr = $urandom;
            pc = pc + 32'd4;
        end
        // noise between candidates
        if ($urandom_range(0, 5) == 0)
            push_word(1'b0, $urandom, $urandom, $urandom);
    endtask

    task automatic test_random_scans(input int unsigned src_pct, input int unsigned snk_pct,
                                     input int unsigned count, input bit drain_midway);
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        for (int unsigned c = 0; c < count; c++)
        begin
            if (drain_midway && c == count / 2)
                wait_results_done();
            scan_candidate();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 13;
        snk_stall_pct = 83;
        test_idle_and_empty();
        test_return_cases();
        test_rejects();
        test_register_tracking();
        test_forward_targets();
        test_address_wrap();

        test_random_scans(13, 83, 25, 1'b1);
        test_random_scans(83, 13, 25, 1'b0);
        test_random_scans(0, 0, 25, 1'b0);

        wait_results_done();
        repeat (8) @(posedge clk);
        if (err_count == 0)
            $display("mips_function_end_scanner_tb OK");
        else
            $display("mips_function_end_scanner_tb NOT OK");
        $finish;
    end

endmodule
